>>> rtl/pal_pkg.sv
// package: shared types, codes and constants for the positional array list
`timescale 1ns / 1ps

package pal_pkg;

    localparam int WORD_W       = 32;
    localparam int POS_W        = 7;
    localparam int KIND_W       = 2;
    localparam int STATUS_W     = 2;
    localparam int CAPACITY_DEF = 64;
    localparam int FAN_IN       = 8;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 48;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_GET    = 2'd2,
        KIND_SET    = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_READ = 1'b1
    } fsm_t;

    // broadcast to every cell in the row
    typedef struct packed {
        logic              insert_en;
        logic              remove_en;
        logic              set_en;
        logic [POS_W-1:0]  pos;
        logic [WORD_W-1:0] value;
    } cell_ctrl_t;

endpackage

>>> rtl/pal_cell.sv
// one list entry: shifts up on insert, down on remove, loads on set
`timescale 1ns / 1ps

module pal_cell
    import pal_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  logic              aclk,
    input  cell_ctrl_t        ctrl,
    input  logic [POS_W-1:0]  rd_pos,
    input  logic [WORD_W-1:0] left_word,
    input  logic [WORD_W-1:0] right_word,
    output logic [WORD_W-1:0] entry_word,
    output logic [WORD_W-1:0] rd_word
);

    // cells beyond what a position can address are never at or below it
    localparam bit               HIGH = INDEX >= (1 << POS_W);
    localparam logic [POS_W-1:0] IDX  = POS_W'(INDEX % (1 << POS_W));

    logic [WORD_W-1:0] entry_reg;
    logic [WORD_W-1:0] entry_next;
    logic              at_pos;
    logic              above_pos;
    logic              rd_hit;

    assign at_pos    = !HIGH && (IDX == ctrl.pos);
    assign above_pos = HIGH || (IDX > ctrl.pos);
    assign rd_hit    = !HIGH && (IDX == rd_pos);

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.insert_en) begin
            if (above_pos) begin
                entry_next = left_word;
            end else if (at_pos) begin
                entry_next = ctrl.value;
            end
        end else if (ctrl.remove_en) begin
            if (above_pos || at_pos) begin
                entry_next = right_word;
            end
        end else if (ctrl.set_en && at_pos) begin
            entry_next = ctrl.value;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry_word = entry_reg;
    assign rd_word    = rd_hit ? entry_reg : '0;

endmodule

>>> rtl/pal_read_tree.sv
// registered or-tree that gathers the one selected cell word
`timescale 1ns / 1ps

module pal_read_tree
    import pal_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int LEVELS   = 2
) (
    input  logic              aclk,
    input  logic [WORD_W-1:0] leaf [CAPACITY],
    output logic [WORD_W-1:0] word
);

    logic [WORD_W-1:0] tree_reg [LEVELS][CAPACITY];

    for (genvar l = 0; l < LEVELS; l++) begin : g_level
        for (genvar j = 0; j < CAPACITY; j++) begin : g_node
            logic [WORD_W-1:0] part [FAN_IN];
            logic [WORD_W-1:0] acc;
            for (genvar k = 0; k < FAN_IN; k++) begin : g_in
                if (j * FAN_IN + k < CAPACITY) begin : g_used
                    if (l == 0) begin : g_leaf
                        assign part[k] = leaf[j * FAN_IN + k];
                    end else begin : g_inner
                        assign part[k] = tree_reg[l-1][j * FAN_IN + k];
                    end
                end else begin : g_pad
                    assign part[k] = '0;
                end
            end
            always_comb begin
                acc = '0;
                for (int k = 0; k < FAN_IN; k++) begin
                    acc = acc | part[k];
                end
            end
            always_ff @(posedge aclk) begin
                tree_reg[l][j] <= acc;
            end
        end
    end

    assign word = tree_reg[LEVELS-1][0];

endmodule

>>> rtl/positional_array_list.sv
// top level: positional array list built as a row of shifting cells
//
//   channel | direction | tdata (lsb up)                        | tuser
//   s_      | in        | position[6:0], value[38:7]            | kind[1:0]
//   m_      | out       | read_data[31:0], status[33:32],       | -
//           |           | item_count[40:34], is_empty[41]       |
//
// insert, remove and set are applied at the edge that accepts them: every cell loads from its
// neighbour in the same edge. a get in range registers its position, then passes through the
// registered or-tree (fan-in 8) that gathers the word before the result is registered.
// aresetn clears the count and the handshake state; entry words are not reset.
// the output register frees the input side: a new word is taken while a result
// waits if m_tready takes that result in the same cycle.
`timescale 1ns / 1ps

module positional_array_list
    import pal_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // position[6:0], value[38:7]
    input  logic [KIND_W-1:0]   s_tuser,   // kind[1:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // read_data, status, item_count, is_empty
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int EXT_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int LEVELS = ($clog2(CAPACITY) + 2) / 3;
    localparam int WAIT_W = $clog2(LEVELS + 1);

    fsm_t                state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [WAIT_W-1:0]   wait_reg, wait_next;
    logic [POS_W-1:0]    rd_pos_reg, rd_pos_next;
    logic                m_valid_reg, m_valid_next;
    logic [WORD_W-1:0]   m_word_reg, m_word_next;
    status_t             m_status_reg, m_status_next;
    logic [CNT_W-1:0]    m_count_reg, m_count_next;

    kind_t               kind;
    logic [POS_W-1:0]    pos;
    logic [WORD_W-1:0]   value;
    logic [EXT_W-1:0]    pos_ext;
    logic [EXT_W-1:0]    count_ext;
    logic [EXT_W-1:0]    m_count_ext;
    logic                out_free;
    logic                accept;
    status_t             status;
    cell_ctrl_t          ctrl;

    logic [WORD_W-1:0]   entry_word [CAPACITY];
    logic [WORD_W-1:0]   rd_word    [CAPACITY];
    logic [WORD_W-1:0]   tree_word;

    assign kind      = kind_t'(s_tuser);
    assign pos       = s_tdata[POS_W-1:0];
    assign value     = s_tdata[POS_W +: WORD_W];
    assign pos_ext   = EXT_W'(pos);
    assign count_ext = EXT_W'(count_reg);

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == FSM_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        status = STATUS_DONE;
        case (kind)
            KIND_INSERT: begin
                if (pos_ext > count_ext) begin
                    status = STATUS_RANGE;
                end else if (count_reg == CNT_W'(CAPACITY)) begin
                    status = STATUS_FULL;
                end
            end
            default: begin
                if (pos_ext >= count_ext) begin
                    status = STATUS_RANGE;
                end
            end
        endcase
    end

    always_comb begin
        ctrl.insert_en = accept && (status == STATUS_DONE) && (kind == KIND_INSERT);
        ctrl.remove_en = accept && (status == STATUS_DONE) && (kind == KIND_REMOVE);
        ctrl.set_en    = accept && (status == STATUS_DONE) && (kind == KIND_SET);
        ctrl.pos       = pos;
        ctrl.value     = value;
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        wait_next     = wait_reg;
        rd_pos_next   = rd_pos_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_word_next   = m_word_reg;
        m_status_next = m_status_reg;
        m_count_next  = m_count_reg;
        case (state_reg)
            FSM_IDLE: begin
                if (accept) begin
                    if ((kind == KIND_GET) && (status == STATUS_DONE)) begin
                        state_next  = FSM_READ;
                        wait_next   = WAIT_W'(LEVELS);
                        rd_pos_next = pos;
                    end else begin
                        if (ctrl.insert_en) begin
                            count_next = count_reg + 1'b1;
                        end else if (ctrl.remove_en) begin
                            count_next = count_reg - 1'b1;
                        end
                        m_valid_next  = 1'b1;
                        m_word_next   = '0;
                        m_status_next = status;
                        m_count_next  = count_next;
                    end
                end
            end
            FSM_READ: begin
                if (wait_reg != '0) begin
                    wait_next = wait_reg - 1'b1;
                end else if (out_free) begin
                    state_next    = FSM_IDLE;
                    m_valid_next  = 1'b1;
                    m_word_next   = tree_word;
                    m_status_next = STATUS_DONE;
                    m_count_next  = count_reg;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_IDLE;
            count_reg   <= '0;
            wait_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            wait_reg    <= wait_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_pos_reg   <= rd_pos_next;
        m_word_reg   <= m_word_next;
        m_status_reg <= m_status_next;
        m_count_reg  <= m_count_next;
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [WORD_W-1:0] left_word;
        logic [WORD_W-1:0] right_word;
        if (i == 0) begin : g_first
            assign left_word = entry_word[i];
        end else begin : g_left
            assign left_word = entry_word[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_word = entry_word[i];
        end else begin : g_right
            assign right_word = entry_word[i+1];
        end
        pal_cell #(
            .INDEX(i)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .rd_pos     (rd_pos_reg),
            .left_word  (left_word),
            .right_word (right_word),
            .entry_word (entry_word[i]),
            .rd_word    (rd_word[i])
        );
    end

    pal_read_tree #(
        .CAPACITY(CAPACITY),
        .LEVELS  (LEVELS)
    ) u_read_tree (
        .aclk(aclk),
        .leaf(rd_word),
        .word(tree_word)
    );

    // small capacities give a count narrower than the item_count field
    assign m_count_ext = EXT_W'(m_count_reg);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0,
                       (m_count_reg == '0),
                       m_count_ext[POS_W-1:0],
                       m_status_reg,
                       m_word_reg};

endmodule

>>> dv/positional_array_list_tb.sv
// testbench: positional array list driven over both streams and checked against a list model
`timescale 1ns / 1ps

module positional_array_list_tb;
    import pal_pkg::*;

    localparam int LIST_DEPTH  = CAPACITY_DEF;
    localparam int ITEMS_PER_PHASE = 467;
    localparam int TAIL_CYCLES = 20;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        kind_t             kind;
        logic [POS_W-1:0]  pos;
        logic [WORD_W-1:0] value;
        bit                typed;
        logic [WORD_W-1:0] rd;
        status_t           status;
        logic [POS_W-1:0]  cnt;
        logic              empty;
    } list_req_t;

    typedef struct {
        logic [WORD_W-1:0] read_data;
        status_t           status;
        logic [POS_W-1:0]  item_count;
        logic              is_empty;
    } list_result_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // position[6:0], value[38:7]
    logic [KIND_W-1:0]   s_tuser;   // kind[1:0]
    logic                m_tvalid;
    logic                m_tready;
    // read_data[31:0], status[33:32], item_count[40:34], is_empty[41]
    logic [M_DATA_W-1:0] m_tdata;

    // model of the list contents
    logic [WORD_W-1:0] list_words [LIST_DEPTH];
    int unsigned       list_count;

    list_result_t expected_results [$];
    list_req_t    directed_reqs [$];
    int           fail_count;
    int           cycle_count;
    int           send_idle_pct;
    int           rcv_idle_pct;

    positional_array_list #(
        .CAPACITY(LIST_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic list_result_t apply_list_op(kind_t k, logic [POS_W-1:0] pos,
                                                   logic [WORD_W-1:0] val);
        list_result_t r;
        int unsigned  p;
        int unsigned  i;
        r.read_data = '0;
        r.status    = STATUS_DONE;
        p           = 32'(pos);
        case (k)
            KIND_INSERT: begin
                if (p > list_count) begin
                    r.status = STATUS_RANGE;
                end else if (list_count >= LIST_DEPTH) begin
                    r.status = STATUS_FULL;
                end else begin
                    for (i = list_count; i > p; i--)
                        list_words[i] = list_words[i-1];
                    list_words[p] = val;
                    list_count++;
                end
            end
            KIND_REMOVE: begin
                if (p >= list_count) begin
                    r.status = STATUS_RANGE;
                end else begin
                    for (i = p; i + 1 < list_count; i++)
                        list_words[i] = list_words[i+1];
                    list_count--;
                end
            end
            KIND_GET: begin
                if (p >= list_count)
                    r.status = STATUS_RANGE;
                else
                    r.read_data = list_words[p];
            end
            default: begin
                if (p >= list_count)
                    r.status = STATUS_RANGE;
                else
                    list_words[p] = val;
            end
        endcase
        r.item_count = list_count[POS_W-1:0];
        r.is_empty   = (list_count == 0);
        return r;
    endfunction

    // offers one word, waits for the handshake, then books its expected result
    task automatic send_request(list_req_t req);
        list_result_t r;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, req.value, req.pos};
        s_tuser  <= req.kind;
        do @(posedge aclk); while (!s_tready);
        r = apply_list_op(req.kind, req.pos, req.value);
        if (req.typed) begin
            r.read_data  = req.rd;
            r.status     = req.status;
            r.item_count = req.cnt;
            r.is_empty   = req.empty;
        end
        expected_results.push_back(r);
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    always @(posedge aclk) begin : result_check
        list_result_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("result word with nothing expected: %0h", m_tdata);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[31:0] !== want.read_data) begin
                    $error("read_data: expected %0h, got %0h", want.read_data, m_tdata[31:0]);
                    fail_count++;
                end
                if (m_tdata[33:32] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tdata[33:32]);
                    fail_count++;
                end
                if (m_tdata[40:34] !== want.item_count) begin
                    $error("item_count: expected %0d, got %0d", want.item_count,
                           m_tdata[40:34]);
                    fail_count++;
                end
                if (m_tdata[41] !== want.is_empty) begin
                    $error("is_empty: expected %0d, got %0d", want.is_empty, m_tdata[41]);
                    fail_count++;
                end
            end
        end
    end

    initial begin : stimulus
        list_req_t req;
        int        roll;
        int        lim;
        int        ph;
        bit        filling;

        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = KIND_INSERT;
        m_tready      = 1'b0;
        fail_count    = 0;
        cycle_count   = 0;
        send_idle_pct = 16;
        rcv_idle_pct  = 46;
        list_count    = 0;
        filling       = 1'b1;

        // empty list: every access refused
        directed_reqs.push_back('{KIND_GET,    7'd0,   32'h0,         1, 32'h0,
                                  STATUS_RANGE, 7'd0, 1'b1});
        directed_reqs.push_back('{KIND_REMOVE, 7'd0,   32'h1234_5678, 1, 32'h0,
                                  STATUS_RANGE, 7'd0, 1'b1});
        directed_reqs.push_back('{KIND_SET,    7'd0,   32'h5,         1, 32'h0,
                                  STATUS_RANGE, 7'd0, 1'b1});
        directed_reqs.push_back('{KIND_INSERT, 7'd1,   32'h5,         1, 32'h0,
                                  STATUS_RANGE, 7'd0, 1'b1});
        directed_reqs.push_back('{KIND_INSERT, 7'd127, 32'h0,         1, 32'h0,
                                  STATUS_RANGE, 7'd0, 1'b1});
        // extremes of the word
        directed_reqs.push_back('{KIND_INSERT, 7'd0,   32'h7fff_ffff, 1, 32'h0,
                                  STATUS_DONE, 7'd1, 1'b0});
        directed_reqs.push_back('{KIND_INSERT, 7'd0,   32'h8000_0000, 1, 32'h0,
                                  STATUS_DONE, 7'd2, 1'b0});
        directed_reqs.push_back('{KIND_GET,    7'd0,   32'hdead_beef, 1, 32'h8000_0000,
                                  STATUS_DONE, 7'd2, 1'b0});
        directed_reqs.push_back('{KIND_GET,    7'd1,   32'h0,         1, 32'h7fff_ffff,
                                  STATUS_DONE, 7'd2, 1'b0});
        directed_reqs.push_back('{KIND_GET,    7'd2,   32'h0,         1, 32'h0,
                                  STATUS_RANGE, 7'd2, 1'b0});
        // append, insert in the middle, overwrite
        directed_reqs.push_back('{KIND_INSERT, 7'd2,   32'h0,         0, 32'h0,
                                  STATUS_DONE, 7'd0, 1'b0});
        directed_reqs.push_back('{KIND_INSERT, 7'd1,   32'hffff_ffff, 0, 32'h0,
                                  STATUS_DONE, 7'd0, 1'b0});
        directed_reqs.push_back('{KIND_GET,    7'd1,   32'h0,         0, 32'h0,
                                  STATUS_DONE, 7'd0, 1'b0});
        directed_reqs.push_back('{KIND_GET,    7'd2,   32'h0,         0, 32'h0,
                                  STATUS_DONE, 7'd0, 1'b0});
        directed_reqs.push_back('{KIND_SET,    7'd3,   32'h5555_5555, 0, 32'h0,
                                  STATUS_DONE, 7'd0, 1'b0});
        directed_reqs.push_back('{KIND_GET,    7'd3,   32'h0,         0, 32'h0,
                                  STATUS_DONE, 7'd0, 1'b0});
        directed_reqs.push_back('{KIND_SET,    7'd64,  32'haaaa_aaaa, 1, 32'h0,
                                  STATUS_RANGE, 7'd4, 1'b0});
        // removes from the middle, the end and the front until empty
        directed_reqs.push_back('{KIND_REMOVE, 7'd1,   32'h0,         0, 32'h0,
                                  STATUS_DONE, 7'd0, 1'b0});
        directed_reqs.push_back('{KIND_GET,    7'd1,   32'h0,         0, 32'h0,
                                  STATUS_DONE, 7'd0, 1'b0});
        directed_reqs.push_back('{KIND_REMOVE, 7'd2,   32'h0,         0, 32'h0,
                                  STATUS_DONE, 7'd0, 1'b0});
        directed_reqs.push_back('{KIND_REMOVE, 7'd0,   32'h0,         0, 32'h0,
                                  STATUS_DONE, 7'd0, 1'b0});
        directed_reqs.push_back('{KIND_REMOVE, 7'd0,   32'h0,         0, 32'h0,
                                  STATUS_DONE, 7'd0, 1'b0});
        directed_reqs.push_back('{KIND_GET,    7'd0,   32'h0,         1, 32'h0,
                                  STATUS_RANGE, 7'd0, 1'b1});
        directed_reqs.push_back('{KIND_REMOVE, 7'd0,   32'h0,         1, 32'h0,
                                  STATUS_RANGE, 7'd0, 1'b1});

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_reqs[n])
            send_request(directed_reqs[n]);

        for (ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 16 : (ph == 1) ? 46 : 0;
            rcv_idle_pct  = (ph == 0) ? 46 : (ph == 1) ? 16 : 0;
            repeat (ITEMS_PER_PHASE) begin
                // sweep the list up to full and back down to empty
                roll = $urandom_range(0, 99);
                if (filling)
                    req.kind = (roll < 55) ? KIND_INSERT : (roll < 65) ? KIND_REMOVE :
                               (roll < 85) ? KIND_GET : KIND_SET;
                else
                    req.kind = (roll < 10) ? KIND_INSERT : (roll < 65) ? KIND_REMOVE :
                               (roll < 85) ? KIND_GET : KIND_SET;
                lim  = (req.kind == KIND_INSERT) ? list_count + 1 : list_count;
                roll = $urandom_range(0, 99);
                if (roll < 85 && lim > 0)
                    req.pos = POS_W'($urandom_range(0, lim - 1));
                else if (roll < 93)
                    req.pos = POS_W'($urandom_range(lim, 127));
                else
                    req.pos = POS_W'($urandom_range(0, 127));
                roll = $urandom_range(0, 99);
                req.value = (roll < 5) ? 32'h8000_0000 : (roll < 10) ? 32'h7fff_ffff :
                            $urandom();
                req.typed = 1'b0;
                send_request(req);
                if (filling && list_count == LIST_DEPTH && $urandom_range(0, 7) == 0)
                    filling = 1'b0;
                else if (!filling && list_count == 0 && $urandom_range(0, 3) == 0)
                    filling = 1'b1;
            end
        end

        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_results.size() != 0) begin
            $error("results still outstanding: %0d", expected_results.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
